FILE: rtl/core/lkv_pkg.sv
// Shared constants, types and codes of the LRU key-value cache.
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    idx_t  free_idx;
    idx_t  victim_idx;
  } lookup_t;

  typedef struct packed {
    logic  fire;
    logic  cmd;
    data_t key;
    data_t value;
  } req_t;

endpackage

FILE: rtl/core/lkv_lookup.sv
// Parallel key compare, free-slot pick and least-recent entry pick.
module lkv_lookup
  import lkv_pkg::*;
(
  input  data_t   key,
  input  data_t   keys   [ENTRIES],
  input  logic    valid  [ENTRIES],
  input  idx_t    rank   [ENTRIES],
  input  cnt_t    count,
  output lookup_t look
);

  cnt_t oldest;

  assign oldest = count - cnt_t'(1);

  always_comb begin
    look = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        look.hit     = 1'b1;
        look.hit_idx = idx_t'(i);
      end
      if (!valid[i]) begin
        look.free_idx = idx_t'(i);
      end
      // Ranks of valid entries are distinct 0..count-1, so the oldest one
      // carries rank count-1.
      if (valid[i] && cnt_t'(rank[i]) == oldest) begin
        look.victim_idx = idx_t'(i);
      end
    end
  end

endmodule

FILE: rtl/core/lkv_store.sv
// Entry storage with recency ranks; applies one get or put per cycle.
module lkv_store
  import lkv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  req_t             req,
  input  logic [CAP_W-1:0] capacity,
  output logic             rsp_hit,
  output data_t            rsp_value
);

  data_t   keys_r   [ENTRIES];
  data_t   values_r [ENTRIES];
  logic    valid_r  [ENTRIES];
  idx_t    rank_r   [ENTRIES];
  cnt_t    count_r;

  lookup_t look;
  cnt_t    eff_cap;
  logic    evict;
  logic    do_touch;
  logic    do_write_key;
  logic    do_write_value;
  logic    do_insert;
  idx_t    target;
  cnt_t    thresh;

  lkv_lookup u_lookup (
    .key   (req.key),
    .keys  (keys_r),
    .valid (valid_r),
    .rank  (rank_r),
    .count (count_r),
    .look  (look)
  );

  always_comb begin
    if (capacity == '0) begin
      eff_cap = cnt_t'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      eff_cap = cnt_t'(ENTRIES);
    end else begin
      eff_cap = cnt_t'(capacity);
    end
  end

  assign evict = (count_r >= eff_cap);

  always_comb begin
    do_touch       = 1'b0;
    do_write_key   = 1'b0;
    do_write_value = 1'b0;
    do_insert      = 1'b0;
    target         = look.hit_idx;
    thresh         = cnt_t'(rank_r[look.hit_idx]);
    if (req.fire) begin
      if (look.hit) begin
        do_touch       = 1'b1;
        do_write_value = (req.cmd == CMD_PUT);
      end else if (req.cmd == CMD_PUT) begin
        do_touch       = 1'b1;
        do_write_key   = 1'b1;
        do_write_value = 1'b1;
        if (evict) begin
          target = look.victim_idx;
          thresh = count_r - cnt_t'(1);
        end else begin
          target    = look.free_idx;
          thresh    = count_r;
          do_insert = 1'b1;
        end
      end
    end
  end

  assign rsp_hit   = look.hit;
  assign rsp_value = look.hit ? values_r[look.hit_idx] : '1;

  always_ff @(posedge clk) begin
    if (do_write_key) begin
      keys_r[target] <= req.key;
    end
    if (do_write_value) begin
      values_r[target] <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
      count_r <= '0;
    end else if (do_touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (idx_t'(i) == target) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && cnt_t'(rank_r[i]) < thresh) begin
          rank_r[i] <= rank_r[i] + idx_t'(1);
        end
      end
      if (do_insert) begin
        valid_r[target] <= 1'b1;
        count_r         <= count_r + cnt_t'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: channel registers and configuration.
//
// A fully associative key-value store with least-recently-used replacement.
// The input channel (in_valid / in_stall) carries one word per command:
// in_command selects get or put, in_key is the key and in_value the data for
// a put. The result channel (out_valid / out_stall) carries one word per get:
// out_hit tells whether the key was present and out_read_value holds the
// stored value, or all ones on a miss. A put produces no result word.
// A word is accepted into an input register and is applied to the store from
// there, where every entry's key is compared in parallel and the recency ranks
// are updated at once. The result word of a get is loaded into the output
// register at the end of the cycle in which the get is applied. The block
// sustains one word per cycle while the receiver does not stall; the rate is
// set by the single compare-and-update pass over the entries.
// When the receiver stalls with a result held, a pending get waits in the
// input register and in_stall rises; puts still pass through.
// The capacity register (cfg_we / cfg_data) limits how many entries are in
// use before eviction starts; zero counts as one. Write it only while idle.
// Synchronous reset empties the store and sets the capacity to 16.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic        [CAP_W-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value
);

  logic [CAP_W-1:0] capacity_r;

  logic  s1_valid_r;
  logic  s1_cmd_r;
  data_t s1_key_r;
  data_t s1_value_r;
  logic  s1_valid_nxt;

  logic  out_valid_r;
  logic  out_hit_r;
  data_t out_value_r;
  logic  out_valid_nxt;

  logic  out_free;
  logic  s1_go;
  logic  in_take;
  req_t  req;
  logic  rsp_hit;
  data_t rsp_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_data;
    end
  end

  // A get needs room in the output register; a put never does.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (s1_cmd_r == CMD_PUT || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_command;
      s1_key_r   <= $unsigned(in_key);
      s1_value_r <= $unsigned(in_value);
    end
  end

  assign req.fire  = s1_go;
  assign req.cmd   = s1_cmd_r;
  assign req.key   = s1_key_r;
  assign req.value = s1_value_r;

  lkv_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .capacity  (capacity_r),
    .rsp_hit   (rsp_hit),
    .rsp_value (rsp_value)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_cmd_r == CMD_GET) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_cmd_r == CMD_GET) begin
      out_hit_r   <= rsp_hit;
      out_value_r <= rsp_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = $signed(out_value_r);

endmodule
